FILE: rtl/core/relr_pkg.sv
// ----------------------------------------------------------------------------
// relr_pkg
// Shared constants and types of the packed relocation table decoder.
// ----------------------------------------------------------------------------
package relr_pkg;

	localparam int BITMAP_BITS = 63;
	localparam int WORD_BYTES  = 8;
	localparam int ADVANCE     = BITMAP_BITS * WORD_BYTES;
	localparam int ADV_W       = $clog2(ADVANCE + 1);
	localparam int LIM_W       = ADV_W - 3;
	localparam int K_W         = $clog2(BITMAP_BITS);
	localparam int Q_DEPTH     = 2;
	localparam int QPTR_W      = $clog2(Q_DEPTH);

	localparam logic [1:0] ERR_OK         = 2'd0;
	localparam logic [1:0] ERR_NO_BASE    = 2'd1;
	localparam logic [1:0] ERR_ADDR_OVF   = 2'd2;
	localparam logic [1:0] ERR_CURSOR_OVF = 2'd3;

	// one classified request handed from front to back
	typedef struct packed {
		logic                   is_base;
		logic [63:0]            base;
		logic [BITMAP_BITS-1:0] bits;
		logic [1:0]             err;
	} qent_t;

endpackage

FILE: rtl/core/relr_front.sv
// ----------------------------------------------------------------------------
// relr_front
// Accepts table words, tracks cursor and fault, and classifies each word.
// ----------------------------------------------------------------------------
module relr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [63:0]          table_word,
	input  logic                 table_start,
	input  logic                 q_full,
	output logic                 q_push,
	output relr_pkg::qent_t      q_data
);

	logic [63:0] cursor_q;
	logic        cur_valid_q;
	logic        fault_q;

	logic [63:0] cur_eff;
	logic        valid_eff;
	logic        fault_eff;
	logic        accept;

	logic [64:0]                      adv_sum;
	logic                             carry;
	logic [relr_pkg::LIM_W-1:0]       limit;
	logic [relr_pkg::LIM_W:0]         lim1;
	logic [relr_pkg::BITMAP_BITS-1:0] bm;
	logic [relr_pkg::BITMAP_BITS-1:0] keep_mask;
	logic                             addr_ovf;

	logic [63:0] cursor_d;
	logic        cur_valid_d;
	logic        fault_d;
	logic        need;

	assign accept    = push && !q_full;
	assign cur_eff   = table_start ? 64'd0 : cursor_q;
	assign valid_eff = table_start ? 1'b0 : cur_valid_q;
	assign fault_eff = table_start ? 1'b0 : fault_q;

	assign bm      = table_word[relr_pkg::BITMAP_BITS:1];
	assign adv_sum = {1'b0, cur_eff} + 65'(relr_pkg::ADVANCE);
	assign carry   = adv_sum[64];
	// headroom below the top of the address space is small when carry is set
	assign limit   = relr_pkg::LIM_W'((~cur_eff[relr_pkg::ADV_W-1:0]) >> 3);
	assign lim1    = {1'b0, limit} + 1'b1;
	assign keep_mask = ~({relr_pkg::BITMAP_BITS{1'b1}} << lim1);
	assign addr_ovf  = carry && (|(bm & ~keep_mask));

	always_comb begin
		cursor_d       = cur_eff;
		cur_valid_d    = valid_eff;
		fault_d        = fault_eff;
		need           = 1'b0;
		q_data.is_base = 1'b0;
		q_data.base    = table_word;
		q_data.bits    = '0;
		q_data.err     = relr_pkg::ERR_OK;
		if (!fault_eff) begin
			if (!table_word[0]) begin
				need           = 1'b1;
				q_data.is_base = 1'b1;
				cursor_d       = table_word + 64'(relr_pkg::WORD_BYTES);
				cur_valid_d    = 1'b1;
			end else if (!valid_eff) begin
				need       = 1'b1;
				q_data.err = relr_pkg::ERR_NO_BASE;
				fault_d    = 1'b1;
			end else begin
				q_data.base = cur_eff;
				if (addr_ovf) begin
					q_data.bits = bm & keep_mask;
					q_data.err  = relr_pkg::ERR_ADDR_OVF;
					fault_d     = 1'b1;
				end else if (carry) begin
					q_data.bits = bm;
					q_data.err  = relr_pkg::ERR_CURSOR_OVF;
					fault_d     = 1'b1;
				end else begin
					q_data.bits = bm;
					cursor_d    = adv_sum[63:0];
				end
				need = (|q_data.bits) || (q_data.err != relr_pkg::ERR_OK);
			end
		end
	end

	assign q_push = accept && need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			cur_valid_q <= 1'b0;
			fault_q     <= 1'b0;
		end else if (accept) begin
			cursor_q    <= cursor_d;
			cur_valid_q <= cur_valid_d;
			fault_q     <= fault_d;
		end
	end

endmodule

FILE: rtl/core/relr_fifo.sv
// ----------------------------------------------------------------------------
// relr_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module relr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  relr_pkg::qent_t wdata,
	input  logic            rd,
	output relr_pkg::qent_t rdata,
	output logic            full,
	output logic            empty
);

	relr_pkg::qent_t mem_q [relr_pkg::Q_DEPTH];

	logic [relr_pkg::QPTR_W-1:0] wptr_q;
	logic [relr_pkg::QPTR_W-1:0] rptr_q;
	logic [relr_pkg::QPTR_W:0]   cnt_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full  = (cnt_q == (relr_pkg::QPTR_W + 1)'(relr_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/relr_back.sv
// ----------------------------------------------------------------------------
// relr_back
// Emits base addresses, walks bitmap requests bit by bit into slot addresses, and emits error codes.
// ----------------------------------------------------------------------------
module relr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  relr_pkg::qent_t q_data,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [63:0]     slot_address,
	output logic [1:0]      error_code,
	output logic            last_of_run
);

	logic                             busy_q;
	logic                             is_base_q;
	logic [63:0]                      base_q;
	logic [relr_pkg::BITMAP_BITS-1:0] rem_q;
	logic [relr_pkg::K_W-1:0]         k_q;
	logic [1:0]                       err_q;

	logic        ov_q;
	logic [63:0] addr_q;
	logic [1:0]  code_q;
	logic        last_q;

	logic                             out_free;
	logic [relr_pkg::BITMAP_BITS-1:0] rem_next;

	assign out_free = !ov_q || pop;
	assign q_pop    = !busy_q && !q_empty;
	assign rem_next = rem_q >> 1;

	assign empty        = !ov_q;
	assign slot_address = addr_q;
	assign error_code   = code_q;
	assign last_of_run  = last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			is_base_q <= q_data.is_base;
			base_q    <= q_data.base;
			rem_q     <= q_data.bits;
			err_q     <= q_data.err;
			k_q       <= '0;
		end else if (busy_q && out_free && !is_base_q && (|rem_q)) begin
			rem_q <= rem_next;
			k_q   <= k_q + 1'b1;
		end
		if (busy_q && out_free) begin
			if (is_base_q) begin
				addr_q <= base_q;
				code_q <= relr_pkg::ERR_OK;
				last_q <= 1'b1;
			end else if (|rem_q) begin
				addr_q <= base_q + (64'(k_q) << 3);
				code_q <= relr_pkg::ERR_OK;
				last_q <= (rem_next == '0) && (err_q == relr_pkg::ERR_OK);
			end else begin
				addr_q <= '0;
				code_q <= err_q;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && out_free) begin
				if (is_base_q || (rem_q == '0)) begin
					busy_q <= 1'b0;
				end else if ((rem_next == '0) && (err_q == relr_pkg::ERR_OK)) begin
					busy_q <= 1'b0;
				end
			end
			if (busy_q && out_free && (is_base_q || (rem_q == '0) || rem_q[0])) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/relr_relocation_decoder.sv
// ----------------------------------------------------------------------------
// relr_relocation_decoder
// Packed relative-relocation table decoder: base words and bitmap words in,
// relocation slot addresses and decode errors out.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      table_word[63:0], table_start
//  result    pop / empty      slot_address[63:0], error_code[1:0], last_of_run
//
//  the front takes one word a cycle while the two-entry queue has room
//  the back loads a request, then scans one bitmap bit per cycle while its output is free
//  a bitmap word holds the back for its load, a scan of up to 63 bits and any error result
//  a base word holds it for its load and its result; a result passes the queue, request and output registers
//  the back stalls while a result waits unpopped; full rises once the queue fills
//  reset clears cursor, fault, queue and output valid
// ----------------------------------------------------------------------------
module relr_relocation_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] table_word,
	input  logic        table_start,
	input  logic        pop,
	output logic        empty,
	output logic [63:0] slot_address,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	relr_pkg::qent_t f_data;
	relr_pkg::qent_t b_data;
	logic            f_push;
	logic            b_pop;
	logic            q_empty;

	relr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.table_word  (table_word),
		.table_start (table_start),
		.q_full      (full),
		.q_push      (f_push),
		.q_data      (f_data)
	);

	relr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (f_data),
		.rd     (b_pop),
		.rdata  (b_data),
		.full   (full),
		.empty  (q_empty)
	);

	relr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (b_data),
		.q_empty      (q_empty),
		.q_pop        (b_pop),
		.pop          (pop),
		.empty        (empty),
		.slot_address (slot_address),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule
